// File: rtl/core/gregorian_date_day_arithmetic_macros.svh
// assertion macros shared by the date arithmetic block
`ifndef GREGORIAN_DATE_DAY_ARITHMETIC_MACROS_SVH
`define GREGORIAN_DATE_DAY_ARITHMETIC_MACROS_SVH

// consequence must hold in the same cycle as the antecedent
`define GDDA_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define GDDA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gdda_pkg.sv
// shared types, constants and the month offset table of the date arithmetic block
package gdda_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_SUB  = 2'd1,
        FUNC_DIFF = 2'd2,
        FUNC_CMP  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } order_t;

    // day number width, covers the largest date plus the largest offset
    localparam int JDN_W   = 24;
    // biased year width (year + 4800)
    localparam int YFULL_W = 17;

    // yy / 100 as (yy * 5243) >> 19, exact for yy below 2**15
    localparam logic [12:0] Y100_RECIP = 13'd5243;
    localparam int          Y100_SHIFT = 19;

    localparam logic [JDN_W-1:0]   JDN_EPOCH  = 24'd32045;
    localparam logic [JDN_W-1:0]   INV_EPOCH  = 24'd32044;
    localparam logic [YFULL_W-1:0] YEAR_BIAS  = 17'd4800;
    localparam logic [YFULL_W-1:0] YEAR_LO    = 17'd4801;
    localparam logic [21:0]        COUNT_MAX  = 22'h3FFFFF;
    // march-based month index from which the date falls in the next year
    localparam logic [3:0]         MONTH_ROLL = 4'd10;

    typedef struct packed {
        func_t       func;
        logic        ok;
        logic [21:0] count;
        order_t      order;
    } ctl_t;

    // days before a march-based month: (153 * mm + 2) / 5
    function automatic logic [8:0] month_offset(input logic [3:0] mm);
        logic [8:0] off;
        case (mm)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

// File: rtl/core/gdda_jdn.sv
// three-stage conversion of a gregorian date to its day number
module gdda_jdn
    import gdda_pkg::*;
(
    input  logic             clk,
    input  logic [2:0]       en,     // stage loads, earliest stage in bit 0
    input  logic [13:0]      year,
    input  logic [3:0]       month,
    input  logic [4:0]       day,
    output logic [JDN_W-1:0] jdn
);

    logic             early;
    logic [14:0]      yy;
    logic [3:0]       mm;
    logic [8:0]       mt;
    logic [14:0]      yy_a_reg;
    logic [8:0]       mt_a_reg;
    logic [27:0]      q100_prod;
    logic [22:0]      y365;
    logic [14:0]      yy_b_reg;
    logic [8:0]       mt_b_reg;
    logic [7:0]       q100_reg;
    logic [22:0]      y365_reg;
    logic [JDN_W-1:0] jdn_next;
    logic [JDN_W-1:0] jdn_reg;

    // january and february count as months of the previous year
    always_comb
    begin
        early = (month <= 4'd2);
        yy    = 15'(year) + 15'd4800 - 15'(early);
        mm    = early ? month + 4'd9 : month - 4'd3;
        mt    = 9'(day) + month_offset(mm);
    end

    always_comb
    begin
        q100_prod = 28'(yy_a_reg) * 28'(Y100_RECIP);
        y365      = 23'(yy_a_reg) * 23'd365;
    end

    always_comb
    begin
        jdn_next = JDN_W'(y365_reg) + JDN_W'(yy_b_reg[14:2]) + JDN_W'(q100_reg[7:2])
                 + JDN_W'(mt_b_reg) - JDN_W'(q100_reg) - JDN_EPOCH;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            yy_a_reg <= yy;
            mt_a_reg <= mt;
        end
        if (en[1])
        begin
            yy_b_reg <= yy_a_reg;
            mt_b_reg <= mt_a_reg;
            q100_reg <= q100_prod[Y100_SHIFT +: 8];
            y365_reg <= y365;
        end
        if (en[2])
        begin
            jdn_reg <= jdn_next;
        end
    end

    assign jdn = jdn_reg;

endmodule

// File: rtl/core/gdda_div.sv
// three-stage division by a constant: reciprocal estimate, remainder, one correction
module gdda_div
    import gdda_pkg::*;
#(
    parameter int DIVISOR = 146097,
    parameter int XW      = 26
)
(
    input  logic                        clk,
    input  logic [2:0]                  en,
    input  logic [XW-1:0]               x,
    output logic [XW-$clog2(DIVISOR):0] quot,
    output logic [$clog2(DIVISOR)-1:0]  rem
);

    localparam int RW = $clog2(DIVISOR);
    localparam int QW = XW - RW + 1;
    localparam longint unsigned RECIP_L = (64'd1 << XW) / 64'(DIVISOR);
    localparam logic [QW-1:0]   RECIP   = QW'(RECIP_L);
    localparam logic [XW-1:0]   DIV_X   = XW'(DIVISOR);
    localparam logic [RW:0]     DIV_R   = (RW+1)'(DIVISOR);

    logic [XW+QW-1:0] prod;
    logic [XW+QW-1:0] prod_reg;
    logic [XW-1:0]    x_reg;
    logic [QW-1:0]    q_est;
    logic [XW-1:0]    back;
    logic [XW-1:0]    r_full;
    logic [QW-1:0]    q_b_reg;
    logic [RW:0]      r_b_reg;
    logic             fix;
    logic [QW-1:0]    q_next;
    logic [RW:0]      r_next;
    logic [QW-1:0]    q_reg;
    logic [RW-1:0]    r_reg;

    // estimate is the true quotient or one below it
    always_comb
    begin
        prod   = (XW+QW)'(x) * (XW+QW)'(RECIP);
        q_est  = prod_reg[XW +: QW];
        back   = XW'(q_est) * DIV_X;
        r_full = x_reg - back;
        fix    = (r_b_reg >= DIV_R);
        q_next = fix ? q_b_reg + QW'(1) : q_b_reg;
        r_next = fix ? r_b_reg - DIV_R : r_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= prod;
            x_reg    <= x;
        end
        if (en[1])
        begin
            q_b_reg <= q_est;
            r_b_reg <= r_full[RW:0];
        end
        if (en[2])
        begin
            q_reg <= q_next;
            r_reg <= r_next[RW-1:0];
        end
    end

    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// File: rtl/core/gdda_date.sv
// seven-stage conversion of a day number back to a gregorian date
module gdda_date
    import gdda_pkg::*;
(
    input  logic               clk,
    input  logic [6:0]         en,         // stage loads, earliest stage in bit 0
    input  logic [25:0]        x,          // 4 * (day number + 32044) + 3
    output logic [YFULL_W-1:0] year_full,  // year + 4800
    output logic [3:0]         month,
    output logic [4:0]         day
);

    logic [8:0]         cent;
    logic [17:0]        cent_rem;
    logic [17:0]        x2;
    logic [7:0]         quad;
    logic [10:0]        quad_rem;
    logic [8:0]         cent_d_reg [3];
    logic [8:0]         e;
    logic [3:0]         mm;
    logic               roll;
    logic [8:0]         day_full;
    logic [YFULL_W-1:0] year_next;
    logic [3:0]         month_next;
    logic [YFULL_W-1:0] year_reg;
    logic [3:0]         month_reg;
    logic [4:0]         day_reg;

    // 400-year cycles
    gdda_div #(
        .DIVISOR (146097),
        .XW      (26)
    ) u_div_cent (
        .clk  (clk),
        .en   (en[2:0]),
        .x    (x),
        .quot (cent),
        .rem  (cent_rem)
    );

    // 4 * (remainder / 4) + 3
    assign x2 = {cent_rem[17:2], 2'b11};

    // 4-year cycles
    gdda_div #(
        .DIVISOR (1461),
        .XW      (18)
    ) u_div_quad (
        .clk  (clk),
        .en   (en[5:3]),
        .x    (x2),
        .quot (quad),
        .rem  (quad_rem)
    );

    always_comb
    begin
        e  = quad_rem[10:2];
        mm = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (e >= month_offset(4'(k)))
            begin
                mm = 4'(k);
            end
        end
        roll       = (mm >= MONTH_ROLL);
        day_full   = e - month_offset(mm) + 9'd1;
        month_next = roll ? mm - 4'd9 : mm + 4'd3;
        year_next  = YFULL_W'(cent_d_reg[2]) * YFULL_W'(100) + YFULL_W'(quad)
                   + YFULL_W'(roll);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            cent_d_reg[0] <= cent;
        end
        if (en[4])
        begin
            cent_d_reg[1] <= cent_d_reg[0];
        end
        if (en[5])
        begin
            cent_d_reg[2] <= cent_d_reg[1];
        end
        if (en[6])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_full[4:0];
        end
    end

    assign year_full = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;

endmodule

// File: rtl/core/gregorian_date_day_arithmetic.sv
// top level of the gregorian date day arithmetic block
// Each request carries an operation in tuser (add days, subtract days, day difference,
// compare) and two dates plus a day offset in tdata. Dates go through a day number
// (julian day) and, for add and subtract, back to a date. The block is a 13-stage
// pipeline with a valid bit per stage: it takes one request every cycle while the
// output is not stalled and returns the results in request order. Each stage
// loads whenever it is empty or some stage after it can move, so bubbles are squeezed
// out and new requests are still taken while a finished result waits at the output
// register, until every stage is full. The two constant divisions of the inverse
// conversion are the deepest part, each a reciprocal multiply, a remainder and one
// correction over three stages. Status is 1 for an invalid input date (day 0, month 0
// or above 12, year 0) and 2 when an add or subtract gives a year outside
// 1..YEAR_MAX; all other result fields are then zero. Days beyond a month's length
// roll into the next month. The day difference saturates at 4194303.
`include "gregorian_date_day_arithmetic_macros.svh"

module gregorian_date_day_arithmetic
    import gdda_pkg::*;
#(
    parameter int YEAR_MAX = 9999
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // first_year, first_month, first_day, other_year, other_month, other_day,
    // day_offset, zero fill
    input  logic [71:0] s_axis_tdata,
    // func
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_year, result_month, result_day, day_count, order, zero fill
    output logic [47:0] m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser
);

    localparam int N = 13;
    localparam logic [YFULL_W-1:0] YEAR_HI = YFULL_W'(4800 + YEAR_MAX);

    // control carried alongside the forward conversion
    typedef struct packed {
        func_t       func;
        logic        ok;
        logic [19:0] offset;
    } pre_t;

    // pipeline control
    logic [N:1]         valid_reg;
    logic [N:1]         valid_next;
    logic [N:1]         valid_in;
    logic [N:1]         stage_ready;

    // stage 1: request registers
    func_t              in_func_reg;
    logic [13:0]        in_fy_reg;
    logic [3:0]         in_fm_reg;
    logic [4:0]         in_fd_reg;
    logic [13:0]        in_oy_reg;
    logic [3:0]         in_om_reg;
    logic [4:0]         in_od_reg;
    logic [19:0]        in_off_reg;

    logic               first_ok;
    logic               other_ok;
    pre_t               pre_next;
    pre_t               pre_reg [2:4];

    logic [JDN_W-1:0]   jdn_first;
    logic [JDN_W-1:0]   jdn_other;

    // stage 5: shift the day number and settle difference and compare
    logic [JDN_W-1:0]   shifted;
    logic [JDN_W-1:0]   diff;
    logic [21:0]        count;
    order_t             ord;
    ctl_t               ctl_next;
    ctl_t               ctl_reg [5:12];
    logic [25:0]        x_next;
    logic [25:0]        x_reg;

    logic [YFULL_W-1:0] year_full;
    logic [YFULL_W-1:0] year_off;
    logic [3:0]         date_month;
    logic [4:0]         date_day;

    // stage 13: output register
    logic [13:0]        out_year_next;
    logic [3:0]         out_month_next;
    logic [4:0]         out_day_next;
    logic [21:0]        out_count_next;
    order_t             out_order_next;
    status_t            out_status_next;
    logic [13:0]        out_year_reg;
    logic [3:0]         out_month_reg;
    logic [4:0]         out_day_reg;
    logic [21:0]        out_count_reg;
    order_t             out_order_reg;
    status_t            out_status_reg;

    // a stage is blocked only when it and every stage after it hold a request
    // and the output is not taken
    for (genvar k = 1; k <= N; k++)
    begin : g_ready
        assign stage_ready[k] = m_axis_tready || !(&valid_reg[N:k]);
    end

    assign valid_in   = {valid_reg[N-1:1], s_axis_tvalid};
    assign valid_next = (stage_ready & valid_in) | (~stage_ready & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = stage_ready[1];
    assign m_axis_tvalid = valid_reg[N];

    // stage 1 capture
    always_ff @(posedge clk)
    begin
        if (stage_ready[1])
        begin
            in_func_reg <= func_t'(s_axis_tuser);
            in_fy_reg   <= s_axis_tdata[13:0];
            in_fm_reg   <= s_axis_tdata[17:14];
            in_fd_reg   <= s_axis_tdata[22:18];
            in_oy_reg   <= s_axis_tdata[36:23];
            in_om_reg   <= s_axis_tdata[40:37];
            in_od_reg   <= s_axis_tdata[45:41];
            in_off_reg  <= s_axis_tdata[65:46];
        end
    end

    // date checks: add and subtract look at the primary date only
    always_comb
    begin
        first_ok = (in_fy_reg != '0) && (in_fm_reg != '0) && (in_fm_reg <= 4'd12)
                && (in_fd_reg != '0);
        other_ok = (in_oy_reg != '0) && (in_om_reg != '0) && (in_om_reg <= 4'd12)
                && (in_od_reg != '0);
        pre_next.func   = in_func_reg;
        pre_next.ok     = first_ok && ((in_func_reg == FUNC_ADD) || (in_func_reg == FUNC_SUB)
                        || other_ok);
        pre_next.offset = in_off_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[2])
        begin
            pre_reg[2] <= pre_next;
        end
        for (int k = 3; k <= 4; k++)
        begin
            if (stage_ready[k])
            begin
                pre_reg[k] <= pre_reg[k-1];
            end
        end
    end

    // stages 2 to 4: both dates to day numbers
    gdda_jdn u_jdn_first (
        .clk   (clk),
        .en    (stage_ready[4:2]),
        .year  (in_fy_reg),
        .month (in_fm_reg),
        .day   (in_fd_reg),
        .jdn   (jdn_first)
    );

    gdda_jdn u_jdn_other (
        .clk   (clk),
        .en    (stage_ready[4:2]),
        .year  (in_oy_reg),
        .month (in_om_reg),
        .day   (in_od_reg),
        .jdn   (jdn_other)
    );

    // stage 5 logic
    always_comb
    begin
        if (pre_reg[4].func == FUNC_SUB)
        begin
            shifted = jdn_first + INV_EPOCH - JDN_W'(pre_reg[4].offset);
        end
        else
        begin
            shifted = jdn_first + INV_EPOCH + JDN_W'(pre_reg[4].offset);
        end
        x_next = {shifted, 2'b11};

        diff  = (jdn_first >= jdn_other) ? jdn_first - jdn_other : jdn_other - jdn_first;
        count = (diff[JDN_W-1:22] != '0) ? COUNT_MAX : diff[21:0];

        if (jdn_first < jdn_other)
        begin
            ord = ORD_LESS;
        end
        else if (jdn_first == jdn_other)
        begin
            ord = ORD_EQUAL;
        end
        else
        begin
            ord = ORD_GREATER;
        end

        ctl_next.func  = pre_reg[4].func;
        ctl_next.ok    = pre_reg[4].ok;
        ctl_next.count = (pre_reg[4].ok && (pre_reg[4].func == FUNC_DIFF)) ? count : '0;
        ctl_next.order = (pre_reg[4].ok && (pre_reg[4].func == FUNC_CMP)) ? ord : ORD_LESS;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[5])
        begin
            x_reg      <= x_next;
            ctl_reg[5] <= ctl_next;
        end
        for (int k = 6; k <= 12; k++)
        begin
            if (stage_ready[k])
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // stages 6 to 12: day number back to a date
    gdda_date u_date (
        .clk       (clk),
        .en        (stage_ready[12:6]),
        .x         (x_reg),
        .year_full (year_full),
        .month     (date_month),
        .day       (date_day)
    );

    // stage 13: range check and result assembly
    always_comb
    begin
        year_off        = year_full - YEAR_BIAS;
        out_year_next   = '0;
        out_month_next  = '0;
        out_day_next    = '0;
        out_count_next  = ctl_reg[12].count;
        out_order_next  = ctl_reg[12].order;
        out_status_next = STAT_OK;
        if (!ctl_reg[12].ok)
        begin
            out_status_next = STAT_INVALID;
        end
        else if ((ctl_reg[12].func == FUNC_ADD) || (ctl_reg[12].func == FUNC_SUB))
        begin
            if ((year_full < YEAR_LO) || (year_full > YEAR_HI))
            begin
                out_status_next = STAT_RANGE;
            end
            else
            begin
                out_year_next  = year_off[13:0];
                out_month_next = date_month;
                out_day_next   = date_day;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[N])
        begin
            out_year_reg   <= out_year_next;
            out_month_reg  <= out_month_next;
            out_day_reg    <= out_day_next;
            out_count_reg  <= out_count_next;
            out_order_reg  <= out_order_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_axis_tdata = {1'b0, out_order_reg, out_count_reg, out_day_reg, out_month_reg,
                           out_year_reg};
    assign m_axis_tuser = out_status_reg;

    // an empty pipeline always takes a request
    `GDDA_CHECK_NOW(a_empty_takes, valid_reg == '0, s_axis_tready, "empty pipeline stalled")
    // a failed request carries nothing but its status
    `GDDA_CHECK_NOW(a_fail_clear, m_axis_tvalid && (m_axis_tuser != STAT_OK), m_axis_tdata == '0, "failed result not cleared")
    // a returned date is a real calendar position and excludes a day count
    `GDDA_CHECK_NOW(a_date_sane, m_axis_tvalid && (m_axis_tuser == STAT_OK) && (out_month_reg != '0), (out_month_reg <= 4'd12) && (out_day_reg != '0) && (out_count_reg == '0), "bad date result")
    // an invalid request has no count or order from stage 5 onwards
    `GDDA_CHECK_NOW(a_ctl_clear, valid_reg[5] && !ctl_reg[5].ok, (ctl_reg[5].count == '0) && (ctl_reg[5].order == ORD_LESS), "invalid request kept a result")

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the gregorian date day arithmetic block
module tb;
    import gdda_pkg::*;

    localparam int YEAR_LIMIT   = 9999;
    localparam int RANDOM_REQS  = 1000;
    // cycles without any handshake before the run is declared hung
    localparam int IDLE_LIMIT   = 5000;
    // pipeline is 13 deep, give it some slack after the last result
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        func_t       func;
        logic [13:0] first_year;
        logic [3:0]  first_month;
        logic [4:0]  first_day;
        logic [13:0] other_year;
        logic [3:0]  other_month;
        logic [4:0]  other_day;
        logic [19:0] day_offset;
    } date_req_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [21:0] count;
        order_t      order;
        status_t     status;
    } date_res_t;

    bit          clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    date_req_t pending_reqs[$];
    date_res_t expected_results[$];

    logic in_taken;
    int   idle_cycles;
    int   mismatches;
    int   gap_left;
    int   burst_left;
    int   func_seen[4];
    int   status_seen[3];
    int   results_checked;

    // receiver stall pattern state
    logic [15:0] ready_pattern;
    logic [5:0]  stall_phase;
    logic        coin_ready;

    gregorian_date_day_arithmetic #(
        .YEAR_MAX (YEAR_LIMIT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // date arithmetic predictor
    // ---------------------------------------------------------------

    function automatic bit date_valid(longint y, longint m, longint d);
        return d > 0 && m > 0 && m < 13 && y > 0;
    endfunction

    // gregorian date to julian day number, month term (14 - m) / 12
    function automatic longint day_number(longint y, longint m, longint d);
        longint a;
        longint yy;
        longint mm;
        a  = (14 - m) / 12;
        yy = y + 4800 - a;
        mm = m + 12 * a - 3;
        return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
    endfunction

    // julian day number back to a gregorian date
    function automatic void date_from_day_number(input longint j, output longint y,
                                                 output longint m, output longint d);
        longint a;
        longint b;
        longint c;
        longint dd;
        longint e;
        longint mm;
        a  = j + 32044;
        b  = (4 * a + 3) / 146097;
        c  = a - (146097 * b) / 4;
        dd = (4 * c + 3) / 1461;
        e  = c - (1461 * dd) / 4;
        mm = (5 * e + 2) / 153;
        d  = e - (153 * mm + 2) / 5 + 1;
        m  = mm + 3 - 12 * (mm / 10);
        y  = 100 * b + dd - 4800 + mm / 10;
    endfunction

    function automatic date_res_t compute_date_result(date_req_t r);
        date_res_t res;
        longint    j1;
        longint    j2;
        longint    j;
        longint    y;
        longint    m;
        longint    d;
        longint    span;
        res        = '0;
        res.order  = ORD_LESS;
        res.status = STAT_OK;
        if (!date_valid(r.first_year, r.first_month, r.first_day) ||
            ((r.func == FUNC_DIFF || r.func == FUNC_CMP) &&
             !date_valid(r.other_year, r.other_month, r.other_day)))
        begin
            res.status = STAT_INVALID;
        end
        else
        begin
            j1 = day_number(r.first_year, r.first_month, r.first_day);
            if (r.func == FUNC_ADD || r.func == FUNC_SUB)
            begin
                j = (r.func == FUNC_ADD) ? j1 + r.day_offset : j1 - r.day_offset;
                date_from_day_number(j, y, m, d);
                if (y < 1 || y > YEAR_LIMIT)
                    res.status = STAT_RANGE;
                else
                begin
                    res.year  = y[13:0];
                    res.month = m[3:0];
                    res.day   = d[4:0];
                end
            end
            else
            begin
                j2 = day_number(r.other_year, r.other_month, r.other_day);
                if (r.func == FUNC_DIFF)
                begin
                    span = (j1 > j2) ? j1 - j2 : j2 - j1;
                    res.count = (span > longint'(COUNT_MAX)) ? COUNT_MAX : span[21:0];
                end
                else
                    res.order = (j1 < j2) ? ORD_LESS : ((j1 == j2) ? ORD_EQUAL : ORD_GREATER);
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus builders
    // ---------------------------------------------------------------

    task automatic queue_req(func_t f, int fy, int fm, int fd, int oy, int om, int od, int off);
        date_req_t r;
        r.func        = f;
        r.first_year  = 14'(fy);
        r.first_month = 4'(fm);
        r.first_day   = 5'(fd);
        r.other_year  = 14'(oy);
        r.other_month = 4'(om);
        r.other_day   = 5'(od);
        r.day_offset  = 20'(off);
        pending_reqs.push_back(r);
    endtask

    // mostly well-formed dates, leaning on the year edges and month ends
    task automatic queue_random_req();
        date_req_t r;
        r.func = func_t'(2'($urandom_range(0, 3)));
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: wide field values, sometimes giving an invalid date
            r.first_year  = 14'($urandom_range(0, YEAR_LIMIT));
            r.first_month = 4'($urandom_range(0, 15));
            r.first_day   = 5'($urandom_range(0, 31));
            r.other_year  = 14'($urandom_range(0, YEAR_LIMIT));
            r.other_month = 4'($urandom_range(0, 15));
            r.other_day   = 5'($urandom_range(0, 31));
            r.day_offset  = 20'($urandom);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       r.first_year = 14'($urandom_range(1, 60));
                1:       r.first_year = 14'($urandom_range(YEAR_LIMIT - 60, YEAR_LIMIT));
                default: r.first_year = 14'($urandom_range(1, YEAR_LIMIT));
            endcase
            r.first_month = 4'($urandom_range(1, 12));
            r.first_day   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(29, 31))
                                                        : 5'($urandom_range(1, 28));
            case ($urandom_range(0, 2))
                0:       r.day_offset = 20'($urandom_range(0, 31));
                1:       r.day_offset = 20'($urandom_range(0, 5000));
                default: r.day_offset = 20'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:
                begin
                    r.other_year  = r.first_year;
                    r.other_month = r.first_month;
                    r.other_day   = r.first_day;
                end
                1:
                begin
                    r.other_year  = r.first_year;
                    r.other_month = r.first_month;
                    r.other_day   = 5'($urandom_range(1, 31));
                end
                2:
                begin
                    r.other_year  = r.first_year;
                    r.other_month = 4'($urandom_range(1, 12));
                    r.other_day   = 5'($urandom_range(1, 31));
                end
                default:
                begin
                    r.other_year  = 14'($urandom_range(1, YEAR_LIMIT));
                    r.other_month = 4'($urandom_range(1, 12));
                    r.other_day   = 5'($urandom_range(1, 31));
                end
            endcase
        end
        pending_reqs.push_back(r);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ---------------------------------------------------------------
    // request driver: bursts of random length with random gaps
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin : request_driver
        date_req_t nxt;
        logic      launch;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            launch = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_reqs.size() > 0)
            begin
                launch = 1'b1;
                nxt    = pending_reqs.pop_front();
                s_axis_tdata <= {6'd0, nxt.day_offset, nxt.other_day, nxt.other_month,
                                 nxt.other_year, nxt.first_day, nxt.first_month,
                                 nxt.first_year};
                s_axis_tuser <= nxt.func;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                    burst_left--;
            end
            s_axis_tvalid <= launch;
        end
    end

    // ---------------------------------------------------------------
    // result receiver: randomly redrawn stall patterns
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        if (stall_phase == 6'd0)
        begin
            coin_ready = 1'b0;
            case ($urandom_range(0, 3))
                0:       ready_pattern = 16'hFFFF;
                1:       ready_pattern = 16'($urandom) | 16'h0001;
                2:       ready_pattern = 16'($urandom & $urandom & $urandom) | 16'h0001;
                default: coin_ready = 1'b1;
            endcase
        end
        m_axis_tready <= coin_ready ? 1'($urandom_range(0, 1)) : ready_pattern[stall_phase[3:0]];
        stall_phase = stall_phase + 6'd1;
    end

    // ---------------------------------------------------------------
    // monitor: predicts on request acceptance, checks on result acceptance
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : handshake_monitor
        date_req_t got_req;
        date_res_t want;
        logic      out_taken;
        if (rst_n)
        begin
            in_taken  = s_axis_tvalid && s_axis_tready;
            out_taken = m_axis_tvalid && m_axis_tready;
            if (in_taken)
            begin
                got_req.func        = func_t'(s_axis_tuser);
                got_req.first_year  = s_axis_tdata[13:0];
                got_req.first_month = s_axis_tdata[17:14];
                got_req.first_day   = s_axis_tdata[22:18];
                got_req.other_year  = s_axis_tdata[36:23];
                got_req.other_month = s_axis_tdata[40:37];
                got_req.other_day   = s_axis_tdata[45:41];
                got_req.day_offset  = s_axis_tdata[65:46];
                want = compute_date_result(got_req);
                expected_results.push_back(want);
                func_seen[got_req.func]++;
                status_seen[want.status]++;
            end
            if (out_taken)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: tdata %h tuser %h",
                           m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_year",  32'(want.year),   32'(m_axis_tdata[13:0]));
                    check_field("result_month", 32'(want.month),  32'(m_axis_tdata[17:14]));
                    check_field("result_day",   32'(want.day),    32'(m_axis_tdata[22:18]));
                    check_field("day_count",    32'(want.count),  32'(m_axis_tdata[44:23]));
                    check_field("order",        32'(want.order),  32'(m_axis_tdata[46:45]));
                    check_field("status",       32'(want.status), 32'(m_axis_tuser));
                    results_checked++;
                end
            end
            idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // sequence: reset, directed and random requests, drain, verdict
    // ---------------------------------------------------------------

    initial
    begin
        bit timed_out;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_ADD;
        m_axis_tready = 1'b0;
        in_taken      = 1'b0;
        idle_cycles   = 0;
        mismatches    = 0;
        gap_left      = 0;
        burst_left    = 1;
        stall_phase   = 6'd0;
        ready_pattern = 16'hFFFF;
        coin_ready    = 1'b0;
        results_checked = 0;

        // directed: leap days, year edges, offset extremes, invalid dates
        queue_req(FUNC_ADD,  2000,  2, 28,    0,  0,  0, 1);
        queue_req(FUNC_ADD,     1,  1,  1,    0,  0,  0, 0);
        queue_req(FUNC_ADD,     1,  1,  1,    0,  0,  0, 1048575);
        queue_req(FUNC_ADD,  9999, 12, 31,    0,  0,  0, 1);
        queue_req(FUNC_ADD,  9999, 12, 31,    0,  0,  0, 0);
        queue_req(FUNC_SUB,     1,  1,  1,    0,  0,  0, 1);
        queue_req(FUNC_SUB,  9999, 12, 31,    0,  0,  0, 1048575);
        queue_req(FUNC_SUB,  2000,  3,  1,    0,  0,  0, 1);
        // day past the month end rolls into march
        queue_req(FUNC_ADD,  2023,  2, 31,    0,  0,  0, 0);
        queue_req(FUNC_ADD,  1900,  2, 29,    0,  0,  0, 0);
        queue_req(FUNC_ADD,  2000,  0, 10,    0,  0,  0, 5);
        queue_req(FUNC_ADD,  2000, 13, 10,    0,  0,  0, 5);
        queue_req(FUNC_SUB,  2000, 15, 31,    0,  0,  0, 5);
        queue_req(FUNC_ADD,  2000,  5,  0,    0,  0,  0, 5);
        queue_req(FUNC_ADD,     0,  5,  5,    0,  0,  0, 5);
        // add ignores a broken second date
        queue_req(FUNC_ADD,  2000,  5,  5,    0,  0,  0, 10);
        queue_req(FUNC_DIFF, 2000,  5,  5,    0,  5,  5, 0);
        queue_req(FUNC_DIFF,    1,  1,  1, 9999, 12, 31, 0);
        queue_req(FUNC_DIFF, 9999, 12, 31,    1,  1,  1, 1048575);
        queue_req(FUNC_DIFF, 2024,  7,  4, 2024,  7,  4, 0);
        queue_req(FUNC_CMP,  2024,  7,  4, 2024,  7,  5, 0);
        queue_req(FUNC_CMP,  2024,  7,  4, 2024,  7,  4, 0);
        queue_req(FUNC_CMP,  2024,  7,  5, 2024,  7,  4, 0);
        queue_req(FUNC_CMP,  2023,  2, 29, 2023,  3,  1, 0);
        queue_req(FUNC_CMP,  2024,  7,  4, 2024, 13,  1, 0);

        for (int i = 0; i < RANDOM_REQS; i++)
            queue_random_req();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while ((pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
               && idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        timed_out = (idle_cycles >= IDLE_LIMIT);
        if (timed_out)
            $error("no handshake for %0d cycles", idle_cycles);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatches++;
        end

        $display("covered %0d add, %0d subtract, %0d difference, %0d compare requests",
                 func_seen[FUNC_ADD], func_seen[FUNC_SUB], func_seen[FUNC_DIFF],
                 func_seen[FUNC_CMP]);
        $display("%0d results checked: %0d ok, %0d invalid date, %0d year out of range",
                 results_checked, status_seen[STAT_OK], status_seen[STAT_INVALID],
                 status_seen[STAT_RANGE]);
        if (!timed_out && mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/gdda_pkg.sv
rtl/core/gdda_jdn.sv
rtl/core/gdda_div.sv
rtl/core/gdda_date.sv
rtl/core/gregorian_date_day_arithmetic.sv
verif/tb.sv
